// ===== design/assert_macros.svh =====
// Assertion helper macros for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg: shared types for the depth-first component walker
// Holds the request and result payload structs and the request codes.
// ----------------------------------------------------------------------------
package gdc_pkg;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RUN  = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [5:0] edge_from;
      logic [5:0] edge_to;
      logic [6:0] vertex_count;
   } req_type_type;

   typedef struct packed {
      logic [5:0] vertex_id;
      logic       new_component;
      logic [5:0] component_index;
      logic       bad_input;
      logic       last_result;
   } rsp_type_type;

endpackage

// ===== design/gdc_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// gdc_rsp_buf: result output register
// One-entry output register between the walker and the result channel.
// ----------------------------------------------------------------------------
module gdc_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gdc_pkg::rsp_type_type push_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gdc_pkg::rsp_type_type rsp_data
);

   logic                  valid_ff, valid_in;
   gdc_pkg::rsp_type_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (push) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (push) data_ff <= push_data;
   end

   assign full      = valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== design/graph_dfs_components_unit.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_components_unit: depth-first connected-component walker
// Stores undirected edges as per-vertex linked lists in memories and walks them.
// ----------------------------------------------------------------------------
// channel | dir | payload       | handshake
// req     | in  | req_type_type | req_valid / req_stall
// rsp     | out | rsp_type_type | rsp_valid / rsp_stall
//
// Load request: two link appends through the tail memory (S_LD_A, then S_LD_B).
// Run request: S_SCAN and S_ROOT per root candidate; S_TOP, S_LINK, S_CHECK per list
//   entry scanned (plus S_PUSH when its target is in range); S_EMIT per vertex
//   visited; a sweep then clears heads, tails and visited bits before the next request.
// Reset: clearing pass over the same memories; no request taken then.
// A stalled result holds the walker; results leave through one output register,
//   which takes a new result only once the last one has left.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module graph_dfs_components_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gdc_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gdc_pkg::rsp_type_type rsp_data
);

   localparam int SLOTS = 2 * MAX_EDGES;
   localparam int LW    = $clog2(SLOTS);
   localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int FW    = $clog2(MAX_EDGES + 1);
   localparam int DW    = $clog2(MAX_VERTICES + 1);

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_LD_A  = 11'b00000000100,
      S_LD_B  = 11'b00000001000,
      S_SCAN  = 11'b00000010000,
      S_ROOT  = 11'b00000100000,
      S_TOP   = 11'b00001000000,
      S_LINK  = 11'b00010000000,
      S_CHECK = 11'b00100000000,
      S_PUSH  = 11'b01000000000,
      S_EMIT  = 11'b10000000000
   } state_type;

   // list memories: head/tail pointer plus a valid flag (nil when clear)
   logic [LW:0]      head_mem [MAX_VERTICES];
   logic [LW:0]      tail_mem [MAX_VERTICES];
   logic [LW-1:0]    next_mem [SLOTS];
   logic             nnil_mem [SLOTS];
   logic [5:0]       tgt_mem  [SLOTS];
   logic [LW:0]      cur_mem  [MAX_VERTICES];
   logic             seen_mem [MAX_VERTICES];

   state_type   state_ff, state_in;
   logic [VW:0] sweep_ff;
   logic [FW-1:0] fill_ff;
   logic        drop_ff;
   logic [5:0]  a_ff, b_ff;
   logic [6:0]  count_ff;
   logic [6:0]  root_ff;
   logic [5:0]  comp_ff;
   logic [DW-1:0] depth_ff;
   logic [LW:0] cur_rd, head_rd, tail_rd, tail_q;
   logic [LW-1:0] next_rd;
   logic        nnil_rd;
   logic [5:0]  tgt_rd;
   logic        seen_rd;
   logic [5:0]  tv_ff;
   logic        pend_ff;
   gdc_pkg::rsp_type_type pend_data_ff;
   logic        full;

   // memory ports (synchronous read)
   logic [VW-1:0] h_ra, t_ra, c_ra;
   logic [LW-1:0] l_ra;
   logic          h_we, t_we, c_we, l_we, ln_we, s_we;
   logic [VW-1:0] h_wa, t_wa, c_wa, s_wa;
   logic [LW:0]   h_wd, t_wd, c_wd;
   logic [LW-1:0] l_wa, ln_wa, ln_wd;
   logic [5:0]    l_wd;
   logic          s_wd;

   always_ff @(posedge clock) begin
      head_rd <= head_mem[h_ra];
      seen_rd <= seen_mem[h_ra];
      tail_rd <= tail_mem[t_ra];
      cur_rd  <= cur_mem[c_ra];
      next_rd <= next_mem[l_ra];
      nnil_rd <= nnil_mem[l_ra];
      tgt_rd  <= tgt_mem[l_ra];
      if (h_we) head_mem[h_wa] <= h_wd;
      if (s_we) seen_mem[s_wa] <= s_wd;
      if (t_we) tail_mem[t_wa] <= t_wd;
      if (c_we) cur_mem[c_wa]  <= c_wd;
      if (l_we) begin
         tgt_mem[l_wa]  <= l_wd;
         nnil_mem[l_wa] <= 1'b0;
      end
      if (ln_we) begin
         next_mem[ln_wa] <= ln_wd;
         nnil_mem[ln_wa] <= 1'b1;
      end
   end

   wire ld_ok = (fill_ff < FW'(MAX_EDGES)) && (7'(req_data.edge_from) < 7'(MAX_VERTICES))
                && (7'(req_data.edge_to) < 7'(MAX_VERTICES));
   wire [LW-1:0] slot_a = LW'({fill_ff, 1'b0});
   wire [LW-1:0] slot_b = LW'({fill_ff, 1'b1});
   wire [DW-1:0] top    = depth_ff - DW'(1);
   wire [6:0]    eff_cnt = (req_data.vertex_count > 7'(MAX_VERTICES)) ?
                           7'(MAX_VERTICES) : req_data.vertex_count;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      h_ra = VW'(req_data.edge_from); t_ra = VW'(req_data.edge_from);
      c_ra = VW'(top); l_ra = cur_rd[LW-1:0];
      h_we = 1'b0; t_we = 1'b0; c_we = 1'b0; l_we = 1'b0; ln_we = 1'b0; s_we = 1'b0;
      h_wa = VW'(sweep_ff); t_wa = VW'(sweep_ff); c_wa = VW'(top); s_wa = VW'(sweep_ff);
      h_wd = '0; t_wd = '0; c_wd = '0; s_wd = 1'b0;
      l_wa = slot_a; l_wd = b_ff; ln_wa = tail_q[LW-1:0]; ln_wd = slot_a;
      unique case (state_ff)
         S_CLEAR: begin
            h_we = 1'b1; t_we = 1'b1; s_we = 1'b1;
            if (sweep_ff == (VW+1)'(MAX_VERTICES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_data.req_type == gdc_pkg::REQ_LOAD && ld_ok)
               state_in = S_LD_A;
            else if (req_valid && req_data.req_type == gdc_pkg::REQ_RUN)
               state_in = S_SCAN;
         end
         S_LD_A: begin
            // append slot a to list of a, tail of a read last cycle
            l_wa = slot_a; l_wd = b_ff;
            ln_we = tail_rd[LW]; ln_wa = tail_rd[LW-1:0]; ln_wd = slot_a;
            l_we = 1'b1;
            h_we = !tail_rd[LW]; h_wa = VW'(a_ff); h_wd = {1'b1, slot_a};
            t_we = 1'b1; t_wa = VW'(a_ff); t_wd = {1'b1, slot_a};
            t_ra = VW'(b_ff);
            state_in = S_LD_B;
         end
         S_LD_B: begin
            // forward a's new tail when both ends are the same vertex
            l_wa = slot_b; l_wd = a_ff;
            ln_we = 1'b1;
            if (a_ff == b_ff) ln_wa = slot_a;
            else begin
               ln_we = tail_rd[LW]; ln_wa = tail_rd[LW-1:0];
            end
            ln_wd = slot_b;
            l_we = 1'b1;
            h_we = (a_ff != b_ff) && !tail_rd[LW]; h_wa = VW'(b_ff); h_wd = {1'b1, slot_b};
            t_we = 1'b1; t_wa = VW'(b_ff); t_wd = {1'b1, slot_b};
            state_in = S_IDLE;
         end
         S_SCAN: begin
            h_ra = VW'(root_ff);
            if (root_ff >= count_ff) begin
               if (!full) state_in = S_CLEAR;
            end else state_in = S_ROOT;
         end
         S_ROOT: begin
            // hold the read address so head and visited bit stay valid
            h_ra = VW'(root_ff);
            if (seen_rd) state_in = S_SCAN;
            else if (!pend_ff) begin
               c_we = 1'b1; c_wa = '0; c_wd = head_rd;
               s_we = 1'b1; s_wa = VW'(root_ff); s_wd = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!full) state_in = S_TOP;
         end
         S_TOP: begin
            // cursor of top is being read
            state_in = S_LINK;
         end
         S_LINK: begin
            if (!cur_rd[LW]) begin
               state_in = (depth_ff == DW'(1)) ? S_SCAN : S_TOP;
            end else state_in = S_CHECK;
         end
         S_CHECK: begin
            c_we = 1'b1; c_wd = {nnil_rd, next_rd};
            h_ra = VW'(tgt_rd);
            if (7'(tgt_rd) >= count_ff) state_in = S_TOP;
            else if (32'(depth_ff) < MAX_VERTICES) state_in = S_PUSH;
            else state_in = S_TOP;
            c_ra = VW'(top);
         end
         S_PUSH: begin
            h_ra = VW'(tv_ff);
            if (seen_rd) state_in = S_TOP;
            else if (!pend_ff) begin
               c_we = 1'b1; c_wa = VW'(depth_ff); c_wd = head_rd;
               s_we = 1'b1; s_wa = VW'(tv_ff); s_wd = 1'b1;
               state_in = S_EMIT;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_ff <= '0;
         fill_ff  <= '0;
         drop_ff  <= 1'b0;
         depth_ff <= '0;
         pend_ff  <= 1'b0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_CLEAR: sweep_ff <= sweep_ff + (VW+1)'(1);
            S_IDLE: begin
               sweep_ff <= '0;
               if (req_valid) begin
                  a_ff <= req_data.edge_from;
                  b_ff <= req_data.edge_to;
                  if (req_data.req_type == gdc_pkg::REQ_LOAD) begin
                     if (!ld_ok) drop_ff <= 1'b1;
                  end else begin
                     count_ff <= eff_cnt;
                     root_ff  <= '0;
                     comp_ff  <= '0;
                     if (req_data.vertex_count > 7'(MAX_VERTICES)) drop_ff <= 1'b1;
                  end
               end
            end
            S_LD_A: tail_q <= {1'b1, slot_a};
            S_LD_B: fill_ff <= fill_ff + FW'(1);
            S_SCAN: begin
               if (root_ff >= count_ff) begin
                  if (!full) begin
                     fill_ff <= '0; drop_ff <= 1'b0; depth_ff <= '0;
                     if (pend_ff) pend_ff <= 1'b0;
                  end
               end
            end
            S_ROOT: begin
               if (seen_rd) root_ff <= root_ff + 7'd1;
               else if (!pend_ff) begin
                  depth_ff <= DW'(1);
                  tv_ff <= root_ff[5:0];
               end
            end
            S_EMIT: begin
               if (!full) begin
                  pend_ff <= 1'b1;
                  pend_data_ff <= '{vertex_id: tv_ff, new_component: (depth_ff == DW'(1)),
                                    component_index: comp_ff, bad_input: drop_ff,
                                    last_result: 1'b0};
               end
            end
            S_LINK: begin
               if (!cur_rd[LW]) begin
                  depth_ff <= top;
                  if (depth_ff == DW'(1)) begin
                     root_ff <= root_ff + 7'd1;
                     comp_ff <= comp_ff + 6'd1;
                  end
               end
            end
            S_CHECK: begin
               tv_ff <= tgt_rd;
               if (7'(tgt_rd) >= count_ff) drop_ff <= 1'b1;
            end
            S_PUSH: begin
               if (!seen_rd && !pend_ff) depth_ff <= depth_ff + DW'(1);
            end
            default: ;
         endcase
         // pending result: released into the output register once its
         // successor is known (or the run ends, marking it last)
         if (pend_ff && !full && (state_ff == S_ROOT || state_ff == S_PUSH) && !seen_rd) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // pending result goes out when next emit is certain or as the last one
   logic          out_push;
   gdc_pkg::rsp_type_type out_data;
   always_comb begin
      out_data = pend_data_ff;
      out_push = 1'b0;
      if (pend_ff && !full) begin
         if ((state_ff == S_ROOT || state_ff == S_PUSH) && !seen_rd) out_push = 1'b1;
         if (state_ff == S_SCAN && root_ff >= count_ff) begin
            out_push = 1'b1;
            out_data.last_result = 1'b1;
         end
      end
   end

   gdc_rsp_buf u_buf (
      .clock(clock), .reset(reset), .push(out_push), .push_data(out_data),
      .full(full), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   `ASSERT_CLK(a_no_req_busy, clock, reset, (req_valid && !req_stall) |-> (state_ff == S_IDLE),
      "request taken while busy")
   `ASSERT_CLK(a_depth_cap, clock, reset, 32'(depth_ff) <= MAX_VERTICES,
      "stack depth beyond capacity")
   `ASSERT_CLK(a_fill_cap, clock, reset, 32'(fill_ff) <= MAX_EDGES,
      "edge fill beyond capacity")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_CLEAR && !rsp_valid),
      "reset did not clear control")

endmodule
